// ----- rtl/sab_pkg.sv -----
// sab_pkg: shared types and constants for the sector allocation bitmap
// holds the request/response payload structs and the controller/datapath
// command and status bundles; no dependencies
`default_nettype none

package sab_pkg;

    localparam int unsigned NUM_SECTORS_DEF = 65536;
    localparam logic [30:0] DATA_OFFSET_RST = 31'd9728;
    localparam int unsigned SECTOR_SHIFT = 9;     // 512-byte sectors
    localparam logic [7:0]  BYTE_FULL = 8'hFF;

    localparam logic ACT_QUERY = 1'b0;
    localparam logic ACT_MARK  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [15:0] sector;
        logic [16:0] count;
    } t_req;

    typedef struct packed {
        logic        status;
        logic        allocated;
        logic [16:0] run_length;
        logic [30:0] image_offset;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic clr_wr;     // write zero at the sweep address and step
        logic load;       // capture an accepted item
        logic rd;         // read the current bitmap byte
        logic rd_next;    // read the byte after the current one
        logic adv;        // step to the next byte
        logic q_eval;     // evaluate the byte just read for a query
        logic wr_full;    // write all ones to the current byte
        logic wr_or;      // write read data or'ed with the range mask
        logic out_load;   // move the result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;   // sweep is at the last bitmap byte
        logic oor;        // request runs past the last sector
        logic zero_cnt;   // request count is zero
        logic is_mark;    // request is a mark
        logic last_byte;  // current byte holds the last sector of the range
        logic mask_full;  // range covers the whole current byte
        logic hit;        // a differing bit inside the range was found
        logic out_free;   // output register can take a result
    } t_stat;

endpackage

`default_nettype wire

// ----- rtl/sab_ctrl.sv -----
// sab_ctrl: sequencer for the sector allocation bitmap
// runs the clearing sweep, the mark read-modify-write walk and the query walk
// depends on sab_pkg
`default_nettype none

module sab_ctrl
    import sab_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_req_valid,
    output logic       o_req_ready,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_CHECK,
        ST_MK,
        ST_MK_WR,
        ST_Q_RD,
        ST_Q_EV,
        ST_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (i_stat.oor) begin
                    n_state = ST_RESP;
                end else if (i_stat.is_mark) begin
                    n_state = i_stat.zero_cnt ? ST_RESP : ST_MK;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_Q_RD;
                end
            end
            ST_MK: begin
                if (i_stat.mask_full) begin
                    // whole byte in range: no read needed
                    o_cmd.wr_full = 1'b1;
                    if (i_stat.last_byte) begin
                        n_state = ST_RESP;
                    end else begin
                        o_cmd.adv = 1'b1;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ST_MK_WR;
                end
            end
            ST_MK_WR: begin
                o_cmd.wr_or = 1'b1;
                if (i_stat.last_byte) begin
                    n_state = ST_RESP;
                end else begin
                    o_cmd.adv = 1'b1;
                    n_state   = ST_MK;
                end
            end
            ST_Q_RD: begin
                n_state = ST_Q_EV;
            end
            ST_Q_EV: begin
                o_cmd.q_eval = 1'b1;
                if (i_stat.hit || i_stat.last_byte || i_stat.zero_cnt) begin
                    n_state = ST_RESP;
                end else begin
                    // fetch the next byte while this one is judged
                    o_cmd.adv     = 1'b1;
                    o_cmd.rd_next = 1'b1;
                end
            end
            ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/sab_dp.sv -----
// sab_dp: datapath of the sector allocation bitmap
// bitmap memory, request registers, range mask, run evaluation and output stage
// depends on sab_pkg
`default_nettype none

module sab_dp
    import sab_pkg::*;
#(
    parameter int unsigned NUM_SECTORS = NUM_SECTORS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_req        i_req,
    input  wire logic        i_cfg_valid,
    input  wire logic [30:0] i_cfg_data,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic             o_rsp_valid,
    input  wire logic        i_rsp_ready,
    output t_rsp             o_rsp
);

    localparam int unsigned BYTES = (NUM_SECTORS + 7) / 8;
    localparam int unsigned AW_R  = $clog2(BYTES);
    localparam int unsigned AW    = (AW_R > 0) ? AW_R : 1;
    localparam int unsigned NSW   = $clog2(NUM_SECTORS + 1);
    localparam int unsigned PW    = (NSW > 18) ? NSW : 18;   // sector position width
    localparam int unsigned BW    = PW - 3;                  // byte index width

    localparam logic [PW-1:0] NS_POS    = PW'(NUM_SECTORS);
    localparam logic [BW-1:0] LAST_BYTE = BW'(BYTES - 1);

    logic [7:0]    r_mem [BYTES];
    logic [7:0]    r_rdata;
    logic [30:0]   r_data_offset;
    logic [PW-1:0] r_first;
    logic [PW-1:0] r_end;
    logic [BW-1:0] r_last;
    logic [BW-1:0] r_byte;
    logic          r_oor;
    logic          r_zero;
    logic          r_mark;
    logic          r_val;
    logic [16:0]   r_run;
    logic [30:0]   r_off;
    logic          r_rsp_valid;
    t_rsp          r_rsp;

    logic [PW-1:0] sec_pos;
    logic [PW-1:0] end_pos;
    logic [PW-1:0] end_m1;
    logic [BW-1:0] byte_nx;
    logic [BW-1:0] first_byte;
    logic [BW-1:0] end_byte;
    logic [7:0]    lo_mask;
    logic [7:0]    hi_mask;
    logic [7:0]    mask;
    logic          val_cur;
    logic [7:0]    diff;
    logic [2:0]    diff_idx;
    logic [PW-1:0] stop_pos;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    wdata;

    assign sec_pos    = PW'(i_req.sector);
    assign end_pos    = sec_pos + PW'(i_req.count);
    assign end_m1     = end_pos - PW'(1);
    assign byte_nx    = r_byte + BW'(1);
    assign first_byte = r_first[PW-1:3];
    assign end_byte   = r_end[PW-1:3];

    // bits of the current byte that fall inside [first, end)
    always_comb begin
        lo_mask = (r_byte == first_byte) ? (BYTE_FULL << r_first[2:0]) : BYTE_FULL;
        hi_mask = (r_byte == end_byte) ? ((8'h01 << r_end[2:0]) - 8'h01) : BYTE_FULL;
        mask    = lo_mask & hi_mask;
    end

    // the first byte supplies the reference bit itself
    assign val_cur = (r_byte == first_byte) ? r_rdata[r_first[2:0]] : r_val;
    assign diff    = (r_rdata ^ {8{val_cur}}) & mask;

    always_comb begin
        diff_idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (diff[i]) begin
                diff_idx = 3'(i);
            end
        end
    end

    assign stop_pos = {r_byte, diff_idx};

    always_comb begin
        o_stat           = '0;
        o_stat.clr_last  = (r_byte == LAST_BYTE);
        o_stat.oor       = r_oor;
        o_stat.zero_cnt  = r_zero;
        o_stat.is_mark   = r_mark;
        o_stat.last_byte = (r_byte == r_last);
        o_stat.mask_full = (mask == BYTE_FULL);
        o_stat.hit       = |diff;
        o_stat.out_free  = !r_rsp_valid || i_rsp_ready;
    end

    // bitmap memory: one write and one registered read port
    assign mem_we = i_cmd.clr_wr || i_cmd.wr_full || i_cmd.wr_or;
    assign mem_re = i_cmd.rd || i_cmd.rd_next;
    assign waddr  = r_byte[AW-1:0];
    assign raddr  = i_cmd.rd_next ? byte_nx[AW-1:0] : r_byte[AW-1:0];

    always_comb begin
        priority if (i_cmd.clr_wr) begin
            wdata = 8'h00;
        end else if (i_cmd.wr_full) begin
            wdata = BYTE_FULL;
        end else begin
            wdata = r_rdata | mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_offset <= DATA_OFFSET_RST;
        end else if (i_cfg_valid) begin
            r_data_offset <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else begin
            priority if (i_cmd.load) begin
                r_byte <= sec_pos[PW-1:3];
            end else if (i_cmd.clr_wr || i_cmd.adv) begin
                r_byte <= byte_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_first <= sec_pos;
            r_end   <= end_pos;
            r_last  <= end_m1[PW-1:3];
            r_oor   <= (sec_pos >= NS_POS) || (end_pos > NS_POS);
            r_zero  <= (i_req.count == 17'd0);
            r_mark  <= (i_req.action == ACT_MARK);
            r_off   <= r_data_offset + (31'(i_req.sector) << SECTOR_SHIFT);
        end
        if (i_cmd.q_eval) begin
            if (r_byte == first_byte) begin
                r_val <= val_cur;
            end
            r_run <= (|diff) ? 17'(stop_pos - r_first) : 17'(r_end - r_first);
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp.status       <= r_oor;
            r_rsp.allocated    <= (!r_oor && !r_mark) ? r_val : 1'b0;
            r_rsp.run_length   <= (!r_oor && !r_mark) ? r_run : 17'd0;
            r_rsp.image_offset <= r_off;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire

// ----- rtl/sector_allocation_bitmap.sv -----
// sector_allocation_bitmap: one allocated bit per sector for a copy-on-write overlay
// top level, joins the sequencer and the datapath
// depends on sab_pkg, sab_ctrl, sab_dp
//
// Request channel (i_req_valid/o_req_ready, i_req) takes one item at a time:
// a query returns the first sector's bit and the length of the run of equal
// bits from it, capped at count; a mark sets every bit of the range. Each item
// gives one response item on o_rsp_valid/i_rsp_ready with the byte offset
// data_offset + sector*512 of the sector in the overlay data area.
// The cfg channel writes data_offset; it is always ready.
// An item walks the bitmap byte by byte through a single memory port. A query
// reads the next byte while the current one is judged; a mark writes a whole
// byte without a read and a partial byte by a read, then a write. Out-of-range
// items and zero-count marks go to the response without a walk.
// After reset the bitmap is cleared by a sweep over every byte, during which
// no request is taken.
// A stalled response sits in the output register; the next request is still
// accepted and waits at its end for the register to free up.
`default_nettype none

module sector_allocation_bitmap
    import sab_pkg::*;
#(
    parameter int unsigned NUM_SECTORS = NUM_SECTORS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    output logic             o_req_ready,
    input  wire t_req        i_req,
    output logic             o_rsp_valid,
    input  wire logic        i_rsp_ready,
    output t_rsp             o_rsp,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [30:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    sab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    sab_dp #(
        .NUM_SECTORS (NUM_SECTORS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ----- bench/tb_sector_allocation_bitmap.sv -----
// tb_sector_allocation_bitmap: self-checking bench for the sector allocation bitmap
// keeps a bit-level copy of the bitmap and the data offset to predict every response item
// depends on sab_pkg and sector_allocation_bitmap
module tb_sector_allocation_bitmap;
    timeunit 1ns;
    timeprecision 1ps;
    import sab_pkg::*;

    localparam int unsigned NUM_SECTORS = NUM_SECTORS_DEF;
    localparam int unsigned IDLE_LIMIT  = 60000;
    localparam int unsigned HOLD_CYCLES = 3000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    t_req        req_item  = '0;
    logic        rsp_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [30:0] cfg_data  = '0;
    logic        o_req_ready;
    logic        o_rsp_valid;
    t_rsp        rsp_item;
    logic        o_cfg_ready;

    t_req        pending_q[$];
    t_rsp        result_q[$];
    bit          alloc_bits[NUM_SECTORS];
    logic [30:0] offset_mirror = DATA_OFFSET_RST;
    int unsigned send_idle_pct = 0;
    int unsigned rsp_idle_pct  = 0;
    logic        long_hold_req = 1'b0;
    bit          long_hold_done = 1'b0;
    int unsigned hold_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned error_count = 0;
    int unsigned rsp_seen = 0;

    sector_allocation_bitmap u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (req_item),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on response %0d, %s: got %0d expected %0d",
                 rsp_seen, what, got, want);
        error_count++;
    endtask

    // expected response for one accepted request; marks update the bit copy
    function automatic t_rsp predict_request(input t_req r);
        t_rsp        e;
        int unsigned first;
        int unsigned stop;
        int unsigned s;
        bit          v;
        e = '0;
        first = r.sector;
        stop = first + r.count;
        e.image_offset = offset_mirror + {r.sector, 9'd0};
        if (stop > NUM_SECTORS) begin
            e.status = 1'b1;
        end else if (r.action == ACT_QUERY) begin
            v = alloc_bits[first];
            e.allocated = v;
            s = first;
            while (s < stop && alloc_bits[s] == v) s++;
            e.run_length = 17'(s - first);
        end else begin
            for (s = first; s < stop; s++) alloc_bits[s] = 1'b1;
        end
        return e;
    endfunction

    // mostly requests clustered in a few windows so marks and queries overlap,
    // a few fully random ones that mostly run past the end
    function automatic t_req make_random_item();
        t_req        r;
        int unsigned pick;
        int unsigned base;
        pick = $urandom_range(99);
        if (pick < 8) begin
            r.action = 1'($urandom);
            r.sector = 16'($urandom);
            r.count  = 17'($urandom);
            return r;
        end
        r.action = (pick < 38) ? ACT_MARK : ACT_QUERY;
        case ($urandom_range(3))
            0: base = 0;
            1: base = 16384;
            2: base = 36000;
            default: base = NUM_SECTORS - 4096;
        endcase
        r.sector = 16'(base + $urandom_range(4095));
        pick = $urandom_range(99);
        if (pick < 2 && r.action == ACT_QUERY) begin
            r.count = 17'($urandom_range(65536, 4096));
        end else if (pick < 20) begin
            r.count = 17'($urandom_range(300));
        end else begin
            r.count = 17'($urandom_range(24));
        end
        return r;
    endfunction

    task automatic queue_request(input logic act, input int unsigned sec, input int unsigned cnt);
        t_req r;
        r.action = act;
        r.sector = 16'(sec);
        r.count  = 17'(cnt);
        pending_q.push_back(r);
    endtask

    // every item sent and every response back, then a short settle
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_q.size() != 0 || req_valid || result_q.size() != 0);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_offset(input logic [30:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || o_req_ready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req_valid <= 1'b1;
                req_item  <= pending_q.pop_front();
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // response side, with one long hold-off to back the block up
    always @(posedge clk) begin
        if (long_hold_req && !long_hold_done) begin
            hold_left = HOLD_CYCLES;
            long_hold_done = 1'b1;
        end
        if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
        end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // monitor: check responses first, then predict the newly accepted item
    always @(posedge clk) begin
        t_rsp want;
        if (rst_n) begin
            if (cfg_valid && o_cfg_ready) offset_mirror = cfg_data;
            if (o_rsp_valid && rsp_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("response with nothing expected",
                                    32'(rsp_item.image_offset), 0);
                end else begin
                    want = result_q.pop_front();
                    if (rsp_item.status !== want.status)
                        report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
                    if (rsp_item.allocated !== want.allocated)
                        report_mismatch("allocated", 32'(rsp_item.allocated),
                                        32'(want.allocated));
                    if (rsp_item.run_length !== want.run_length)
                        report_mismatch("run_length", 32'(rsp_item.run_length),
                                        32'(want.run_length));
                    if (rsp_item.image_offset !== want.image_offset)
                        report_mismatch("image_offset", 32'(rsp_item.image_offset),
                                        32'(want.image_offset));
                end
                rsp_seen++;
            end
            if (req_valid && o_req_ready) result_q.push_back(predict_request(req_item));
        end
    end

    // watchdog: includes the clearing sweep after reset and the long hold-off
    always @(posedge clk) begin
        if ((req_valid && o_req_ready) || (o_rsp_valid && rsp_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct <= 16;
        rsp_idle_pct  <= 67;
        @(negedge clk);

        // fresh bitmap: edges of the fields, empty counts, ranges past the end
        queue_request(ACT_QUERY, 0, 1);
        queue_request(ACT_QUERY, 0, 0);
        queue_request(ACT_MARK, 0, 0);
        queue_request(ACT_QUERY, 0, 65536);
        queue_request(ACT_QUERY, 65535, 1);
        queue_request(ACT_QUERY, 65535, 2);
        queue_request(ACT_MARK, 65535, 2);
        queue_request(ACT_QUERY, 0, 131071);
        queue_request(ACT_MARK, 3, 21);
        queue_request(ACT_QUERY, 0, 100);
        queue_request(ACT_QUERY, 3, 100);
        queue_request(ACT_QUERY, 5, 4);
        queue_request(ACT_MARK, 64, 8);
        queue_request(ACT_QUERY, 60, 20);
        queue_request(ACT_QUERY, 64, 20);
        queue_request(ACT_MARK, 65528, 8);
        queue_request(ACT_QUERY, 65520, 16);
        queue_request(ACT_QUERY, 65528, 8);
        queue_request(ACT_MARK, 24, 40);
        queue_request(ACT_QUERY, 3, 1000);
        queue_request(ACT_MARK, 65535, 1);
        queue_request(ACT_QUERY, 65535, 0);
        queue_request(ACT_MARK, 0, 65537);
        queue_request(ACT_MARK, 43690, 21845);
        queue_request(ACT_QUERY, 43690, 21846);
        wait_drained();

        long_hold_req <= 1'b1;
        repeat (330) pending_q.push_back(make_random_item());
        wait_drained();

        write_offset(31'd0);
        send_idle_pct <= 67;
        rsp_idle_pct  <= 16;
        repeat (330) pending_q.push_back(make_random_item());
        wait_drained();

        // offset near the top so image_offset wraps
        write_offset(31'h7FFF_FE00);
        send_idle_pct <= 0;
        rsp_idle_pct  <= 0;
        repeat (250) pending_q.push_back(make_random_item());
        wait_drained();

        write_offset(31'h7FFF_FFFF);
        queue_request(ACT_QUERY, 65535, 1);
        repeat (60) pending_q.push_back(make_random_item());
        wait_drained();

        write_offset(31'h4000_0000);
        repeat (100) pending_q.push_back(make_random_item());
        wait_drained();

        repeat (64) @(posedge clk);
        if (result_q.size() != 0)
            report_mismatch("results never returned", 32'(result_q.size()), 0);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sab_pkg.sv
rtl/sab_ctrl.sv
rtl/sab_dp.sv
rtl/sector_allocation_bitmap.sv
bench/tb_sector_allocation_bitmap.sv
